FILE: sv/signed_int_to_decimal_ascii_assert.svh
// Assertion macros used by the back part of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SITDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SITDA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sitda_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package sitda_pkg;

	// Integer width and the decimal digits its magnitude can need
	localparam int VALUE_BITS = 32;
	localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int IDX_W = $clog2(NDIG);
	localparam int BCD_W = NDIG * 4;

	// Binary to BCD conversion: bits consumed per cycle
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_W = STEPS * BITS_PER_STEP;
	localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	// Queue between the front and back parts
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// ASCII codes
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO = 8'd48;

	// One converted number waiting for emission
	typedef struct packed {
		logic             neg;
		logic [IDX_W-1:0] top;
		logic [BCD_W-1:0] bcd;
	} num_entry_t;

endpackage

FILE: sv/sitda_front.sv
// Front part: accepts an integer, takes its magnitude and converts it to BCD.
module sitda_front import sitda_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         in_valid,
	output logic                         in_ready,
	output num_entry_t                   push_data,
	output logic                         push_valid,
	input  logic                         push_ready
);

	typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_t;

	fstate_t                state_q;
	logic [STEP_W-1:0]      step_q;
	logic                   neg_q;
	logic [PAD_W-1:0]       mag_q;
	logic [BCD_W-1:0]       bcd_q;

	logic [VALUE_BITS-1:0]  value_u;
	logic [VALUE_BITS-1:0]  abs_val;
	logic [PAD_W-1:0]       mag_n;
	logic [BCD_W-1:0]       bcd_n;
	logic [IDX_W-1:0]       top;

	// Take the magnitude, so the most negative value needs no special case
	assign value_u = value;
	assign abs_val = value_u[VALUE_BITS-1] ? (VALUE_BITS'(0) - value_u) : value_u;

	// Shift-and-add-3 over a few bits per cycle
	always_comb begin
		mag_n = mag_q;
		bcd_n = bcd_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_n[d*4 +: 4] >= 4'd5) begin
					bcd_n[d*4 +: 4] = bcd_n[d*4 +: 4] + 4'd3;
				end
			end
			{bcd_n, mag_n} = {bcd_n[BCD_W-2:0], mag_n, 1'b0};
		end
	end

	// Find the most significant nonzero digit; zero keeps digit 0
	always_comb begin
		top = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				top = IDX_W'(i);
			end
		end
	end

	assign in_ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_data = '{neg: neg_q, top: top, bcd: bcd_q};

	// Sequence load, conversion steps and hand-off to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q <= '0;
			neg_q <= 1'b0;
			mag_q <= '0;
			bcd_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						neg_q <= value_u[VALUE_BITS-1];
						mag_q <= PAD_W'(abs_val);
						bcd_q <= '0;
						step_q <= STEP_W'(STEPS - 1);
						state_q <= F_CONV;
					end
				end
				F_CONV: begin
					mag_q <= mag_n;
					bcd_q <= bcd_n;
					if (step_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/sitda_fifo.sv
// Short queue of converted numbers between the front and back parts.
module sitda_fifo import sitda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  num_entry_t wr_data,
	input  logic       wr_valid,
	output logic       wr_ready,
	output num_entry_t rd_data,
	output logic       rd_valid,
	input  logic       rd_ready
);

	num_entry_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    do_wr;
	logic                    do_rd;

	assign wr_ready = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/sitda_back.sv
// Back part: emits the sign and digits of one number as ASCII characters.
`include "signed_int_to_decimal_ascii_assert.svh"

module sitda_back import sitda_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  num_entry_t pop_data,
	input  logic       pop_valid,
	output logic       pop_ready,
	output logic [7:0] character,
	output logic       last,
	output logic       out_valid,
	input  logic       out_ready
);

	typedef enum logic {B_IDLE, B_EMIT} bstate_t;

	bstate_t           state_q;
	logic              sign_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [7:0]        character_q;
	logic              last_q;
	logic              out_valid_q;

	logic              slot_free;
	logic              emit;
	logic [3:0]        digit;
	logic              char_legal;
	logic              pop_take;

	assign slot_free = !out_valid_q || out_ready;
	assign emit = (state_q == B_EMIT) && slot_free;
	assign pop_ready = (state_q == B_IDLE);
	assign digit = bcd_q[{idx_q, 2'b00} +: 4];

	assign character = character_q;
	assign last = last_q;
	assign out_valid = out_valid_q;

	// Load a number, then walk from the sign down to the units digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sign_q <= 1'b0;
			idx_q <= '0;
			bcd_q <= '0;
			character_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						sign_q <= pop_data.neg;
						idx_q <= pop_data.top;
						bcd_q <= pop_data.bcd;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (slot_free) begin
						if (sign_q) begin
							character_q <= CH_MINUS;
							last_q <= 1'b0;
							sign_q <= 1'b0;
						end else begin
							character_q <= CH_ZERO + {4'b0000, digit};
							last_q <= (idx_q == '0);
							if (idx_q == '0) begin
								state_q <= B_IDLE;
							end else begin
								idx_q <= idx_q - 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Terms for the checks below
	assign char_legal = (character == CH_MINUS) ||
		(character >= CH_ZERO && character <= CH_ZERO + 8'd9);
	assign pop_take = pop_valid && pop_ready;

	`SITDA_ASSERT_IMP(a_char_legal, out_valid, char_legal, "character is neither minus nor digit")
	`SITDA_ASSERT_IMP(a_minus_not_last, out_valid && character == CH_MINUS, !last, "minus flagged last")
	`SITDA_ASSERT_NEXT(a_pop_starts_emit, pop_take, state_q == B_EMIT, "popped item not emitted")

endmodule

FILE: sv/signed_int_to_decimal_ascii.sv
// The BCD conversion runs at 4 bits per cycle between a load and a hand-off to the queue;
// the front part takes a new integer only after handing the previous one to the queue.
// The back part loads a number, then sends one character per cycle while out_ready allows.
// The queue lets the front part convert the next integer while the back part emits.
// Reset: arst_n clears the queue, both sequencers and the output valid at once.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         in_valid,
	output logic                         in_ready,
	output logic [7:0]                   character,
	output logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready
);

	num_entry_t push_data;
	logic       push_valid;
	logic       push_ready;
	num_entry_t pop_data;
	logic       pop_valid;
	logic       pop_ready;

	// Accept and convert
	sitda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// Decouple conversion from emission
	sitda_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (push_data),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.rd_data  (pop_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready)
	);

	// Emit characters
	sitda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.character (character),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule
